FILE: sv/fwid_pkg.sv
// Shared types, widths and register codes for the field-weakening d-axis reference block.
// No dependencies; every other file of the block imports this package.
package fwid_pkg;

   // Field and datapath widths.
   localparam int SPEED_W    = 16;
   localparam int CFG_W      = 15;
   localparam int QUOT_W     = 15;
   localparam int REM_W      = 15;
   localparam int ENTRY_W    = 16;

   // Curve storage: four 64-bit rows of four 16-bit entries each.
   localparam int LANES       = 4;
   localparam int LANE_W      = 2;
   localparam int CURVE_ROWS  = 4;
   localparam int ROW_AW      = 2;
   localparam int CURVE_SLOTS = CURVE_ROWS * LANES;
   localparam int SLOT_W      = 4;

   // Register port.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;

   // Divider: quotient bits resolved per pipeline stage.
   localparam int DIV_STEP_BITS = 3;
   localparam int DIV_STAGES    = (QUOT_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

   // Defaults for the top-level parameters and reset values.
   localparam int DEF_CURVE_ENTRIES = 16;
   localparam int DEF_FRACTION_BITS = 11;
   localparam logic [CFG_W-1:0] SPAN_RESET = CFG_W'(1);

   // Register indexes (byte address is eight times the index).
   typedef enum logic [REG_IDX_W-1:0] {
      REG_ON_SPEED    = 3'd0,
      REG_SPEED_SPAN  = 3'd1,
      REG_CURVE_0_3   = 3'd2,
      REG_CURVE_4_7   = 3'd3,
      REG_CURVE_8_11  = 3'd4,
      REG_CURVE_12_15 = 3'd5
   } reg_index_type;

   // Scalar configuration seen by the datapath.
   typedef struct packed {
      logic [CFG_W-1:0] on_speed;
      logic [CFG_W-1:0] speed_span;
   } cfg_type;

   // Write of one curve row into the lookup memory.
   typedef struct packed {
      logic                  en;
      logic [ROW_AW-1:0]     row;
      logic [CSR_DATA_W-1:0] data;
   } mem_wr_type;

   // Divider result handed to the interpolation pipeline.
   typedef struct packed {
      logic              valid;
      logic              below;
      logic [QUOT_W-1:0] quot;
   } div_out_type;

endpackage

FILE: sv/field_weakening_id_reference_top.sv
// Field-weakening d-axis current reference: speed in, interpolated curve value out.
// Pipeline: the divider contributes six register stages and the lookup and interpolation five.
// Throughput: one item per cycle; a stalled result backs up the pipeline stage by stage.
// Reset (synchronous): pipeline empty, on_speed 0, span 1, all curve entries read as 0.
// Uses fwid_pkg, fwid_csr, fwid_div and fwid_interp.
module field_weakening_id_reference_top #(
   parameter int CURVE_ENTRIES = fwid_pkg::DEF_CURVE_ENTRIES,
   parameter int FRACTION_BITS = fwid_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fwid_pkg::SPEED_W-1:0] req_motor_speed,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fwid_pkg::ENTRY_W-1:0] rsp_id_reference,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fwid_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fwid_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fwid_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import fwid_pkg::*;

   cfg_type     cfg;
   mem_wr_type  mem_wr;
   div_out_type div_out;
   logic        interp_take;

   // Configuration registers and curve writes.
   fwid_csr #(
      .CURVE_ENTRIES (CURVE_ENTRIES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .mem_wr      (mem_wr)
   );

   // Speed excess and division by the span.
   fwid_div u_div (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_motor_speed (req_motor_speed),
      .cfg             (cfg),
      .out_take        (interp_take),
      .div_out         (div_out)
   );

   // Curve lookup and interpolation.
   fwid_interp #(
      .CURVE_ENTRIES (CURVE_ENTRIES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_interp (
      .clock            (clock),
      .reset            (reset),
      .mem_wr           (mem_wr),
      .div_in           (div_out),
      .take             (interp_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_id_reference (rsp_id_reference)
   );

   // The input is held off only when every stage is full and the result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the pipeline still had room");

   // A divider result held back by the interpolation stages keeps its quotient.
   assert property (@(posedge clock) disable iff (reset)
      (div_out.valid && !interp_take) |=>
         (div_out.valid && $stable(div_out.quot) && $stable(div_out.below)))
      else $error("divider result changed while held");

   // No result appears in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

FILE: sv/fwid_csr.sv
// Register port of the field-weakening block: turn-on speed, span and the curve rows.
// Depends on fwid_pkg; feeds fwid_div (configuration) and fwid_interp (curve writes).
module fwid_csr #(
   parameter int CURVE_ENTRIES = fwid_pkg::DEF_CURVE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fwid_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fwid_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fwid_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output fwid_pkg::cfg_type               cfg,
   output fwid_pkg::mem_wr_type            mem_wr
);
   import fwid_pkg::*;

   reg_index_type               reg_idx;
   logic                        wr_fire;
   logic                        is_curve;
   logic [ROW_AW-1:0]           row_sel;
   logic [CSR_DATA_W-1:0]       lane_mask;
   logic [CSR_DATA_W-1:0]       reg_value;

   logic [CFG_W-1:0]            on_speed_ff;
   logic [CFG_W-1:0]            span_ff;
   logic [CURVE_ROWS-1:0]       row_valid_ff;
   logic [CSR_DATA_W-1:0]       curve_copy [CURVE_ROWS];
   logic [CSR_DATA_W-1:0]       rd_mem_ff;
   logic                        rd_mem_sel_ff;
   logic [CSR_DATA_W-1:0]       rd_reg_ff;

   // Decode the register index from the 8-byte word address.
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W]);
   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      is_curve  = 1'b0;
      reg_value = '0;
      unique case (reg_idx) inside
         REG_ON_SPEED: begin
            reg_value = CSR_DATA_W'(on_speed_ff);
         end
         REG_SPEED_SPAN: begin
            reg_value = CSR_DATA_W'(span_ff);
         end
         REG_CURVE_0_3, REG_CURVE_4_7, REG_CURVE_8_11, REG_CURVE_12_15: begin
            is_curve = 1'b1;
         end
         default: begin
            is_curve  = 1'b0;
            reg_value = '0;
         end
      endcase
   end

   assign row_sel = ROW_AW'(reg_idx - REG_CURVE_0_3);

   // Entries past the configured curve length are dropped on write.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lane_mask[k*ENTRY_W +: ENTRY_W] =
            ((int'(row_sel) * LANES + k) < CURVE_ENTRIES) ? {ENTRY_W{1'b1}} : {ENTRY_W{1'b0}};
      end
   end

   assign mem_wr.en   = wr_fire & is_curve;
   assign mem_wr.row  = row_sel;
   assign mem_wr.data = csr_pwdata & lane_mask;

   // Scalar registers and row valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         on_speed_ff  <= '0;
         span_ff      <= SPAN_RESET;
         row_valid_ff <= '0;
      end else begin
         if (wr_fire && reg_idx == REG_ON_SPEED) begin
            on_speed_ff <= csr_pwdata[CFG_W-1:0];
         end
         if (wr_fire && reg_idx == REG_SPEED_SPAN) begin
            span_ff <= csr_pwdata[CFG_W-1:0];
         end
         if (mem_wr.en) begin
            row_valid_ff[mem_wr.row] <= 1'b1;
         end
      end
   end

   // Readback copy of the curve; read data is captured in the setup cycle.
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         curve_copy[mem_wr.row] <= mem_wr.data;
      end
      if (csr_psel && !csr_penable) begin
         rd_mem_ff     <= curve_copy[row_sel];
         rd_mem_sel_ff <= is_curve & row_valid_ff[row_sel];
         rd_reg_ff     <= reg_value;
      end
   end

   assign csr_prdata = rd_mem_sel_ff ? rd_mem_ff : rd_reg_ff;

   assign cfg.on_speed   = on_speed_ff;
   assign cfg.speed_span = span_ff;

endmodule

FILE: sv/fwid_div.sv
// Input stage and pipelined restoring divider: speed excess over the turn-on speed divided
// by the span, a few quotient bits per stage. Depends on fwid_pkg.
module fwid_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [fwid_pkg::SPEED_W-1:0] req_motor_speed,
   input  fwid_pkg::cfg_type            cfg,
   input  logic                         out_take,
   output fwid_pkg::div_out_type        div_out
);
   import fwid_pkg::*;

   logic signed [SPEED_W:0] excess;
   logic [CFG_W-1:0]        span_eff;

   logic              v_ff     [DIV_STAGES+1];
   logic              below_ff [DIV_STAGES+1];
   logic [REM_W-1:0]  rem_ff   [DIV_STAGES+1];
   logic [QUOT_W-1:0] num_ff   [DIV_STAGES+1];
   logic [QUOT_W-1:0] quot_ff  [DIV_STAGES+1];
   logic              en       [DIV_STAGES+1];

   // A zero span behaves as one.
   assign span_eff = (cfg.speed_span == '0) ? CFG_W'(1) : cfg.speed_span;

   // Speed excess; at or below the turn-on speed the first curve entry applies.
   assign excess = $signed({req_motor_speed[SPEED_W-1], req_motor_speed})
                 - $signed({2'b00, cfg.on_speed});

   // A stage loads when it is empty or its contents move on.
   assign en[DIV_STAGES] = !v_ff[DIV_STAGES] | out_take;
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_en
      assign en[s] = !v_ff[s] | en[s+1];
   end
   assign req_stall = !en[0];

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         below_ff[0] <= excess[SPEED_W] | (excess == '0);
         rem_ff[0]   <= '0;
         num_ff[0]   <= excess[QUOT_W-1:0];
         quot_ff[0]  <= '0;
      end
   end

   // Divider stages, most significant quotient bit first.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [REM_W-1:0]  rem_t;
      logic [QUOT_W-1:0] num_t;
      logic [QUOT_W-1:0] quot_t;
      logic [REM_W:0]    trial;
      logic              ge;

      always_comb begin
         rem_t  = rem_ff[k];
         num_t  = num_ff[k];
         quot_t = quot_ff[k];
         trial  = '0;
         ge     = 1'b0;
         for (int j = 0; j < DIV_STEP_BITS; j++) begin
            if (k * DIV_STEP_BITS + j < QUOT_W) begin
               trial  = {rem_t, num_t[QUOT_W-1]};
               ge     = trial >= {1'b0, span_eff};
               rem_t  = ge ? REM_W'(trial - {1'b0, span_eff}) : trial[REM_W-1:0];
               num_t  = {num_t[QUOT_W-2:0], 1'b0};
               quot_t = {quot_t[QUOT_W-2:0], ge};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en[k+1]) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k+1]) begin
            below_ff[k+1] <= below_ff[k];
            rem_ff[k+1]   <= rem_t;
            num_ff[k+1]   <= num_t;
            quot_ff[k+1]  <= quot_t;
         end
      end
   end

   assign div_out.valid = v_ff[DIV_STAGES];
   assign div_out.below = below_ff[DIV_STAGES];
   assign div_out.quot  = quot_ff[DIV_STAGES];

endmodule

FILE: sv/fwid_interp.sv
// Curve lookup and linear interpolation pipeline: segment select, curve memory read,
// difference, multiply by the fraction, final subtract. Depends on fwid_pkg.
module fwid_interp #(
   parameter int CURVE_ENTRIES = fwid_pkg::DEF_CURVE_ENTRIES,
   parameter int FRACTION_BITS = fwid_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fwid_pkg::mem_wr_type                mem_wr,
   input  fwid_pkg::div_out_type               div_in,
   output logic                                take,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fwid_pkg::ENTRY_W-1:0] rsp_id_reference
);
   import fwid_pkg::*;

   localparam int ENT_W  = $clog2(CURVE_ENTRIES);
   localparam int ENT_XW = (ENT_W > SLOT_W) ? ENT_W : SLOT_W;
   localparam int DIFF_W = ENTRY_W + 1;
   localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
   localparam logic [QUOT_W-1:0] LAST_IDX = QUOT_W'(CURVE_ENTRIES - 1);
   localparam logic [ENT_W-1:0]  LAST_ENT = ENT_W'(CURVE_ENTRIES - 1);

   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // Stage 1 inputs.
   logic [QUOT_W-1:0]        idx;
   logic                     sat;
   logic                     hold;
   logic [ENT_W-1:0]         ent_a_in;
   logic [ENT_W-1:0]         ent_b_in;
   logic [FRACTION_BITS-1:0] frac_in;

   logic [ENT_W-1:0]         ent_a1_ff;
   logic [ENT_W-1:0]         ent_b1_ff;
   logic [FRACTION_BITS-1:0] frac1_ff;

   // Stage 2: memory read.
   logic [ENT_XW-1:0]        ent_ax;
   logic [ENT_XW-1:0]        ent_bx;
   logic [ROW_AW-1:0]        row_a;
   logic [ROW_AW-1:0]        row_b;
   logic                     in_range_a;
   logic                     in_range_b;
   logic [CSR_DATA_W-1:0]    curve_mem [CURVE_ROWS];
   logic [CURVE_ROWS-1:0]    row_valid_ff;

   logic [CSR_DATA_W-1:0]    rd_a2_ff;
   logic [CSR_DATA_W-1:0]    rd_b2_ff;
   logic                     ok_a2_ff;
   logic                     ok_b2_ff;
   logic [LANE_W-1:0]        lane_a2_ff;
   logic [LANE_W-1:0]        lane_b2_ff;
   logic [FRACTION_BITS-1:0] frac2_ff;

   // Stage 3: lane select and difference.
   logic signed [ENTRY_W-1:0] a_word;
   logic signed [ENTRY_W-1:0] b_word;
   logic signed [ENTRY_W-1:0] a3_ff;
   logic signed [DIFF_W-1:0]  diff3_ff;
   logic [FRACTION_BITS-1:0]  frac3_ff;

   // Stage 4: product; stage 5: output.
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod4_ff;
   logic signed [ENTRY_W-1:0] a4_ff;
   logic signed [PROD_W-1:0]  result_wide;
   logic signed [ENTRY_W-1:0] id_reference_ff;

   // Enable chain from the output register back to the divider.
   assign en5  = !v5_ff | !rsp_stall;
   assign en4  = !v4_ff | en5;
   assign en3  = !v3_ff | en4;
   assign en2  = !v2_ff | en3;
   assign en1  = !v1_ff | en2;
   assign take = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= div_in.valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // Segment select. Below the turn-on speed and at the end of the curve the
   // fraction is forced to zero, so the same datapath returns the entry itself.
   assign idx      = div_in.quot >> FRACTION_BITS;
   assign sat      = idx >= LAST_IDX;
   assign hold     = div_in.below | sat;
   assign ent_a_in = div_in.below ? '0 : (sat ? LAST_ENT : idx[ENT_W-1:0]);
   assign ent_b_in = hold ? ent_a_in : ENT_W'(ent_a_in + ENT_W'(1));
   assign frac_in  = hold ? '0 : div_in.quot[FRACTION_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en1) begin
         ent_a1_ff <= ent_a_in;
         ent_b1_ff <= ent_b_in;
         frac1_ff  <= frac_in;
      end
   end

   // Entries beyond the stored rows read as zero.
   assign ent_ax     = ENT_XW'(ent_a1_ff);
   assign ent_bx     = ENT_XW'(ent_b1_ff);
   assign row_a      = ent_ax[SLOT_W-1 -: ROW_AW];
   assign row_b      = ent_bx[SLOT_W-1 -: ROW_AW];
   assign in_range_a = (ent_ax >> SLOT_W) == '0;
   assign in_range_b = (ent_bx >> SLOT_W) == '0;

   // Rows never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_wr.en) begin
         row_valid_ff[mem_wr.row] <= 1'b1;
      end
   end

   // Curve memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         curve_mem[mem_wr.row] <= mem_wr.data;
      end
      if (en2) begin
         rd_a2_ff   <= curve_mem[row_a];
         rd_b2_ff   <= curve_mem[row_b];
         ok_a2_ff   <= in_range_a & row_valid_ff[row_a];
         ok_b2_ff   <= in_range_b & row_valid_ff[row_b];
         lane_a2_ff <= ent_ax[LANE_W-1:0];
         lane_b2_ff <= ent_bx[LANE_W-1:0];
         frac2_ff   <= frac1_ff;
      end
   end

   // Pick the entries out of their rows and form the segment difference.
   assign a_word = ok_a2_ff ? $signed(rd_a2_ff[{lane_a2_ff, 4'd0} +: ENTRY_W]) : '0;
   assign b_word = ok_b2_ff ? $signed(rd_b2_ff[{lane_b2_ff, 4'd0} +: ENTRY_W]) : '0;

   always_ff @(posedge clock) begin
      if (en3) begin
         a3_ff    <= a_word;
         diff3_ff <= DIFF_W'(a_word) - DIFF_W'(b_word);
         frac3_ff <= frac2_ff;
      end
   end

   // Difference times fraction.
   assign prod_in = PROD_W'(diff3_ff) * $signed({1'b0, frac3_ff});

   always_ff @(posedge clock) begin
      if (en4) begin
         prod4_ff <= prod_in;
         a4_ff    <= a3_ff;
      end
   end

   // Arithmetic shift floors the step; the result lies between the two entries.
   assign result_wide = PROD_W'(a4_ff) - (prod4_ff >>> FRACTION_BITS);

   always_ff @(posedge clock) begin
      if (en5) begin
         id_reference_ff <= result_wide[ENTRY_W-1:0];
      end
   end

   assign rsp_valid        = v5_ff;
   assign rsp_id_reference = id_reference_ff;

endmodule

FILE: tb/sv/field_weakening_id_reference_top_tb.sv
// Self-checking testbench for field_weakening_id_reference_top: random speeds against a
// curve-interpolation predictor held in a small scoreboard class. Depends on fwid_pkg and the RTL.
`timescale 1ns / 1ps

module field_weakening_id_reference_top_tb;
   import fwid_pkg::*;

   localparam int MAX_REPORTS       = 10;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int HOLD_OFF_CYCLES   = 300;
   localparam int END_SETTLE_CYCLES = 30;
   localparam int RESET_CYCLES      = 11;
   localparam int RANDOM_PHASES     = 8;
   localparam int ITEMS_PER_PHASE   = 200;
   localparam int FIRST_UNUSED_REG  = REG_CURVE_12_15 + 1;
   localparam int LAST_REG_SLOT     = (1 << REG_IDX_W) - 1;
   localparam int SPEED_MAX         = 32767;
   localparam int SPEED_MIN         = -32768;
   localparam int SEGMENT_SIZE      = 1 << DEF_FRACTION_BITS;

   // Expected d-axis references, computed from a private copy of the configuration.
   class id_ref_scoreboard;
      logic [CFG_W-1:0]          on_speed;
      logic [CFG_W-1:0]          speed_span;
      logic signed [ENTRY_W-1:0] curve [DEF_CURVE_ENTRIES];
      logic signed [ENTRY_W-1:0] expected_refs [$];
      int                        mismatches;

      function new();
         on_speed   = '0;
         speed_span = SPAN_RESET;
         foreach (curve[i]) curve[i] = '0;
         mismatches = 0;
      endfunction

      // Mirror a register write; indexes past the last register are ignored.
      function void write_reg(int idx, logic [CSR_DATA_W-1:0] value);
         int base;
         case (idx)
            REG_ON_SPEED:   on_speed = value[CFG_W-1:0];
            REG_SPEED_SPAN: speed_span = value[CFG_W-1:0];
            REG_CURVE_0_3, REG_CURVE_4_7, REG_CURVE_8_11, REG_CURVE_12_15: begin
               base = (idx - REG_CURVE_0_3) * LANES;
               for (int k = 0; k < LANES; k++) begin
                  if (base + k < DEF_CURVE_ENTRIES)
                     curve[base + k] = value[k*ENTRY_W +: ENTRY_W];
               end
            end
            default: ;
         endcase
      endfunction

      // Piecewise-linear lookup of the magnetizing curve for one speed.
      function logic signed [ENTRY_W-1:0] predict_id_ref(logic signed [SPEED_W-1:0] speed);
         int     excess;
         int     divisor;
         int     quot;
         int     seg;
         int     frac;
         longint near_pt;
         longint far_pt;
         longint step;
         if (int'(speed) <= int'(on_speed))
            return curve[0];
         excess  = int'(speed) - int'(on_speed);
         // A zero span behaves as a span of one.
         divisor = (speed_span == '0) ? 1 : int'(speed_span);
         quot    = excess / divisor;
         seg     = quot >> DEF_FRACTION_BITS;
         frac    = quot & (SEGMENT_SIZE - 1);
         // At or past the last segment the final entry is returned as is.
         if (seg >= DEF_CURVE_ENTRIES - 1)
            return curve[DEF_CURVE_ENTRIES-1];
         near_pt = curve[seg];
         far_pt  = curve[seg + 1];
         // Arithmetic shift gives the floor of the scaled step.
         step    = ((near_pt - far_pt) * frac) >>> DEF_FRACTION_BITS;
         return ENTRY_W'(near_pt - step);
      endfunction

      function void note_speed(logic signed [SPEED_W-1:0] speed);
         expected_refs.push_back(predict_id_ref(speed));
      endfunction

      function void check_id_ref(logic signed [ENTRY_W-1:0] actual);
         logic signed [ENTRY_W-1:0] expected;
         if (expected_refs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: id_reference %0d arrived with no speed outstanding", actual);
            return;
         end
         expected = expected_refs.pop_front();
         if (actual !== expected) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: id_reference expected %0d, got %0d", expected, actual);
         end
      endfunction

      function int pending();
         return expected_refs.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [SPEED_W-1:0]   req_motor_speed = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [ENTRY_W-1:0]   rsp_id_reference;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_paddr = '0;
   logic [CSR_DATA_W-1:0]       csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]       csr_prdata;
   logic                        csr_pready;

   id_ref_scoreboard id_ref_sb = new();
   bit idle_on = 1'b1;
   bit hold_off_req = 1'b0;
   int idle_cycles = 0;

   field_weakening_id_reference_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_motor_speed  (req_motor_speed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_id_reference (rsp_id_reference),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short bursts, now and then a long one.
   function automatic int burst_len();
      if ($urandom_range(0, 99) < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_gap();
      if (!idle_on || $urandom_range(0, 99) < 60)
         return 0;
      return burst_len();
   endfunction

   // Curve entries lean toward the extremes so that segment slopes hit their limits.
   function automatic logic [CSR_DATA_W-1:0] pick_curve_row();
      logic [CSR_DATA_W-1:0] row;
      row = {$urandom, $urandom};
      for (int k = 0; k < LANES; k++) begin
         case ($urandom_range(0, 7))
            0: row[k*ENTRY_W +: ENTRY_W] = 16'h8000;
            1: row[k*ENTRY_W +: ENTRY_W] = 16'h7FFF;
            2: row[k*ENTRY_W +: ENTRY_W] = 16'h0000;
            3: row[k*ENTRY_W +: ENTRY_W] = 16'hFFFF;
            default: ;
         endcase
      end
      return row;
   endfunction

   // Most speeds land above the turn-on point, some anywhere, some on the boundary.
   function automatic logic signed [SPEED_W-1:0] pick_speed();
      int lo;
      lo = int'(id_ref_sb.on_speed);
      case ($urandom_range(0, 9))
         0, 1, 2: return SPEED_W'($urandom);
         3: begin
            case ($urandom_range(0, 3))
               0: return SPEED_W'(lo);
               1: return SPEED_W'((lo < SPEED_MAX) ? lo + 1 : lo);
               2: return SPEED_W'(SPEED_MAX);
               default: return SPEED_W'(SPEED_MIN);
            endcase
         end
         default: return SPEED_W'(lo + $urandom_range(0, SPEED_MAX - lo));
      endcase
   endfunction

   // Register write: a setup phase, then an access phase, then the port returns to idle.
   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      id_ref_sb.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one speed and hold it until the transfer completes.
   task automatic send_speed(input logic signed [SPEED_W-1:0] speed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_motor_speed <= speed;
      do @(posedge clock); while (req_stall !== 1'b0);
      id_ref_sb.note_speed(speed);
   endtask

   // Stop offering and wait until every outstanding reference has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (id_ref_sb.pending() != 0);
   endtask

   task automatic write_curve(input logic [CSR_DATA_W-1:0] r0, input logic [CSR_DATA_W-1:0] r1,
                              input logic [CSR_DATA_W-1:0] r2, input logic [CSR_DATA_W-1:0] r3);
      csr_write(REG_CURVE_0_3, r0);
      csr_write(REG_CURVE_4_7, r1);
      csr_write(REG_CURVE_8_11, r2);
      csr_write(REG_CURVE_12_15, r3);
   endtask

   // Random setting for one phase; upper bits of the scalar writes are noise.
   task automatic random_setting();
      logic [CSR_DATA_W-1:0] value;
      value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: value[CFG_W-1:0] = '0;
         1: value[CFG_W-1:0] = CFG_W'(SPEED_MAX);
         2, 3, 4: value[CFG_W-1:0] = CFG_W'($urandom_range(0, 4095));
         default: value[CFG_W-1:0] = CFG_W'($urandom_range(0, SPEED_MAX));
      endcase
      csr_write(REG_ON_SPEED, value);
      value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: value[CFG_W-1:0] = '0;
         1, 2: value[CFG_W-1:0] = CFG_W'(1);
         3: value[CFG_W-1:0] = CFG_W'(SPEED_MAX);
         4, 5, 6: value[CFG_W-1:0] = CFG_W'($urandom_range(1, 4));
         default: value[CFG_W-1:0] = CFG_W'($urandom_range(1, SPEED_MAX));
      endcase
      csr_write(REG_SPEED_SPAN, value);
      write_curve(pick_curve_row(), pick_curve_row(), pick_curve_row(), pick_curve_row());
      if ($urandom_range(0, 3) == 0)
         csr_write($urandom_range(FIRST_UNUSED_REG, LAST_REG_SLOT), {$urandom, $urandom});
   endtask

   // Result side stalls: random bursts, and one long hold-off on request.
   initial begin : rsp_stall_gen
      int hold_left;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES - 1;
            rsp_stall   <= 1'b1;
         end else if (idle_on && $urandom_range(0, 99) < 20) begin
            hold_left  = burst_len() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         id_ref_sb.check_id_ref(rsp_id_reference);
   end

   // Watchdog on cycles with no transfer on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : main_seq
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset values: all curve entries read as zero.
      send_speed(SPEED_W'(SPEED_MIN));
      send_speed(SPEED_W'(0));
      send_speed(SPEED_W'(SPEED_MAX));
      drain_results();

      // Steepest slopes at the first and last segments, turn-on at zero, span one.
      csr_write(REG_ON_SPEED, '0);
      csr_write(REG_SPEED_SPAN, CSR_DATA_W'(1));
      write_curve(64'hFFFF_1234_8000_7FFF, 64'h0001_7FFF_8000_C000,
                  64'h4000_0000_ABCD_2222, 64'h7FFF_8000_0100_F00F);
      send_speed(SPEED_W'(0));
      send_speed(SPEED_W'(1));
      send_speed(SPEED_W'(SEGMENT_SIZE - 1));
      send_speed(SPEED_W'(SEGMENT_SIZE));
      send_speed(SPEED_W'(2 * SEGMENT_SIZE - 1));
      send_speed(SPEED_W'(14 * SEGMENT_SIZE - 1));
      send_speed(SPEED_W'(15 * SEGMENT_SIZE - 1));
      send_speed(SPEED_W'(15 * SEGMENT_SIZE));
      send_speed(SPEED_W'(SPEED_MAX));
      send_speed(SPEED_W'(-1));
      send_speed(SPEED_W'(SPEED_MIN));
      drain_results();

      // Turn-on at the top of the range: only the first entry comes back.
      csr_write(REG_ON_SPEED, '1);
      send_speed(SPEED_W'(SPEED_MAX));
      drain_results();

      // A zero span acts as a span of one.
      csr_write(REG_ON_SPEED, CSR_DATA_W'(100));
      csr_write(REG_SPEED_SPAN, '0);
      send_speed(SPEED_W'(100));
      send_speed(SPEED_W'(101));
      send_speed(SPEED_W'(SPEED_MAX));
      drain_results();

      // Widest span, plus writes to unused register slots that must change nothing.
      csr_write(REG_ON_SPEED, '0);
      csr_write(REG_SPEED_SPAN, CSR_DATA_W'(SPEED_MAX));
      csr_write(FIRST_UNUSED_REG, '1);
      csr_write(LAST_REG_SLOT, {$urandom, $urandom});
      send_speed(SPEED_W'(SPEED_MAX));
      send_speed(SPEED_W'(SPEED_MAX - 1));
      drain_results();

      // Random phases: one without idling, one with a long result hold-off.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_setting();
         idle_on = (phase != 1);
         if (phase == 2)
            hold_off_req = 1'b1;
         repeat (ITEMS_PER_PHASE) send_speed(pick_speed());
         drain_results();
      end
      idle_on = 1'b1;

      repeat (END_SETTLE_CYCLES) @(posedge clock);
      if (id_ref_sb.mismatches == 0 && id_ref_sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
